// ===== sv/bba_pkg.sv =====
`default_nettype none

package bba_pkg;

	localparam int TOP_ORDER   = 10;
	localparam int TOP_BLOCKS  = 32;
	localparam int MIN_LOG2    = 7;
	localparam int HEADER      = 40;
	localparam int GRAN_W      = 15;
	localparam int GRANULES    = TOP_BLOCKS << TOP_ORDER;
	localparam int ORD_W       = 4;
	localparam int OFF_W       = 22;
	localparam int REQ_W       = 18;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_BLOCK = 2'd1,
		ST_BAD      = 2'd2,
		ST_DUP_FREE = 2'd3
	} status_t;

	typedef struct packed {
		logic             head;
		logic             free;
		logic [ORD_W-1:0] order;
	} gran_t;

	localparam int GRAN_BITS = $bits(gran_t);

	typedef struct packed {
		logic    load;
		logic    clr;
		logic    walk_init;
		logic    walk_rd;
		logic    walk_upd;
		logic    split_init;
		logic    split_step;
		logic    free_rd;
		logic    free_chk;
		logic    buddy_rd;
		logic    merge;
		logic    free_fin;
		logic    emit;
		status_t code;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic is_free_op;
		logic bad_in;
		logic walk_end;
		logic found;
		logic split_end;
		logic head;
		logic free;
		logic at_top;
		logic buddy_ok;
	} sts_t;

endpackage

`default_nettype wire

// ===== sv/bba_ram.sv =====
`default_nettype none

module bba_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 32768
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

// ===== sv/bba_dp.sv =====
`default_nettype none

module bba_dp (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire bba_pkg::cmd_t             cmd,
	output bba_pkg::sts_t                  sts,
	input  wire logic                      operation,
	input  wire logic [bba_pkg::REQ_W-1:0] request_bytes,
	input  wire logic [bba_pkg::OFF_W-1:0] freed_offset,
	output logic      [1:0]                status,
	output logic      [bba_pkg::OFF_W-1:0] payload_offset,
	output logic      [bba_pkg::ORD_W-1:0] granted_order
);

	import bba_pkg::*;

	logic [GRAN_W-1:0] clr_q, g_q, found_q;
	logic [ORD_W-1:0]  o_q, want_q, best_q;
	logic              op_q, bad_q, found_v_q;

	logic              we;
	logic [GRAN_W-1:0] addr;
	gran_t             wdata, rdata;

	logic [ORD_W-1:0]  want_c, rd_ord, o_dec;
	logic              fits_c, bad_c, cand;
	logic [REQ_W:0]    need;
	logic [OFF_W-1:0]  base;
	logic [GRAN_W-1:0] bit_o, bit_dec, g_sel;
	logic [GRAN_W:0]   nxt;

	// Smallest order whose block holds the request plus its header.
	always_comb begin
		need   = {1'b0, request_bytes} + (REQ_W+1)'(HEADER);
		want_c = '0;
		fits_c = 1'b0;
		for (int o = TOP_ORDER; o >= 0; o--) begin
			if (need <= ((REQ_W+1)'(1) << (MIN_LOG2 + o))) begin
				want_c = ORD_W'(o);
				fits_c = 1'b1;
			end
		end
		base = freed_offset - OFF_W'(HEADER);
		if (operation) begin
			bad_c = (freed_offset < OFF_W'(HEADER)) || (base[MIN_LOG2-1:0] != '0);
		end else begin
			bad_c = (request_bytes == '0) || !fits_c;
		end
	end

	assign rd_ord  = (rdata.order > ORD_W'(TOP_ORDER)) ? ORD_W'(TOP_ORDER) : rdata.order;
	assign bit_o   = GRAN_W'(1) << o_q;
	assign o_dec   = o_q - ORD_W'(1);
	assign bit_dec = GRAN_W'(1) << o_dec;
	assign cand    = rdata.head && rdata.free && (rd_ord >= want_q) && (rd_ord < best_q);
	assign nxt     = {1'b0, g_q} + (rdata.head ? ((GRAN_W+1)'(1) << rd_ord) : (GRAN_W+1)'(1));

	always_comb begin
		we    = 1'b0;
		addr  = g_q;
		wdata = '0;
		if (cmd.clr) begin
			we   = 1'b1;
			addr = clr_q;
			if (clr_q[TOP_ORDER-1:0] == '0) begin
				wdata = '{head: 1'b1, free: 1'b1, order: ORD_W'(TOP_ORDER)};
			end
		end else if (cmd.split_step) begin
			we = 1'b1;
			if (o_q != want_q) begin
				addr  = found_q + bit_dec;
				wdata = '{head: 1'b1, free: 1'b1, order: o_dec};
			end else begin
				addr  = found_q;
				wdata = '{head: 1'b1, free: 1'b0, order: want_q};
			end
		end else if (cmd.buddy_rd) begin
			addr = g_q ^ bit_o;
		end else if (cmd.merge) begin
			we   = 1'b1;
			addr = g_q | bit_o;
		end else if (cmd.free_fin) begin
			we    = 1'b1;
			wdata = '{head: 1'b1, free: 1'b1, order: o_q};
		end
	end

	bba_ram #(.WIDTH(GRAN_BITS), .DEPTH(GRANULES)) u_ram (
		.clk   (clk),
		.we    (we),
		.addr  (addr),
		.wdata (wdata),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr) begin
			clr_q <= clr_q + GRAN_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= operation;
			bad_q  <= bad_c;
			want_q <= want_c;
			g_q    <= base[OFF_W-1:MIN_LOG2];
		end
		if (cmd.walk_init) begin
			g_q       <= '0;
			best_q    <= ORD_W'(TOP_ORDER + 1);
			found_v_q <= 1'b0;
		end
		if (cmd.walk_upd) begin
			g_q <= nxt[GRAN_W-1:0];
			if (cand) begin
				best_q    <= rd_ord;
				found_q   <= g_q;
				found_v_q <= 1'b1;
			end
		end
		if (cmd.split_init) begin
			o_q <= best_q;
		end
		if (cmd.split_step && (o_q != want_q)) begin
			o_q <= o_dec;
		end
		if (cmd.free_chk) begin
			o_q <= rd_ord;
		end
		if (cmd.merge) begin
			g_q <= g_q & ~bit_o;
			o_q <= o_q + ORD_W'(1);
		end
		if (cmd.emit) begin
			status <= cmd.code;
			if (cmd.code == ST_OK) begin
				payload_offset <= {g_sel, MIN_LOG2'(0)} + OFF_W'(HEADER);
				granted_order  <= op_q ? o_q : want_q;
			end else begin
				payload_offset <= '0;
				granted_order  <= '0;
			end
		end
	end

	assign g_sel = op_q ? g_q : found_q;

	assign sts.clr_last   = &clr_q;
	assign sts.is_free_op = op_q;
	assign sts.bad_in     = bad_q;
	assign sts.walk_end   = (cand && (rd_ord == want_q)) || nxt[GRAN_W];
	assign sts.found      = found_v_q;
	assign sts.split_end  = (o_q == want_q);
	assign sts.head       = rdata.head;
	assign sts.free       = rdata.free;
	assign sts.at_top     = (o_q >= ORD_W'(TOP_ORDER));
	assign sts.buddy_ok   = rdata.head && rdata.free && (rdata.order == o_q);

	a_split_above: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.split_step && (o_q != want_q)) |-> (o_q > want_q))
		else $error("split step below requested order");

	a_merge_below_top: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.merge |-> (o_q < ORD_W'(TOP_ORDER)))
		else $error("merge at the top order");

	a_grant_found: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && (cmd.code == ST_OK) && !op_q) |-> found_v_q)
		else $error("grant without a found block");

endmodule

`default_nettype wire

// ===== sv/bba_ctrl.sv =====
`default_nettype none

module bba_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	output logic               done,
	input  wire bba_pkg::sts_t sts,
	output bba_pkg::cmd_t      cmd
);

	import bba_pkg::*;

	typedef enum logic [11:0] {
		S_CLEAR  = 12'b0000_0000_0001,
		S_IDLE   = 12'b0000_0000_0010,
		S_DISP   = 12'b0000_0000_0100,
		S_A_RD   = 12'b0000_0000_1000,
		S_A_CHK  = 12'b0000_0001_0000,
		S_A_END  = 12'b0000_0010_0000,
		S_SPLIT  = 12'b0000_0100_0000,
		S_F_RD   = 12'b0000_1000_0000,
		S_F_CHK  = 12'b0001_0000_0000,
		S_M_TEST = 12'b0010_0000_0000,
		S_M_CHK  = 12'b0100_0000_0000,
		S_F_FIN  = 12'b1000_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   done_q;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.code = ST_OK;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				if (sts.bad_in) begin
					cmd.emit = 1'b1;
					cmd.code = ST_BAD;
					state_d  = S_IDLE;
				end else if (sts.is_free_op) begin
					state_d = S_F_RD;
				end else begin
					cmd.walk_init = 1'b1;
					state_d       = S_A_RD;
				end
			end
			S_A_RD: begin
				cmd.walk_rd = 1'b1;
				state_d     = S_A_CHK;
			end
			S_A_CHK: begin
				cmd.walk_upd = 1'b1;
				state_d      = sts.walk_end ? S_A_END : S_A_RD;
			end
			S_A_END: begin
				if (sts.found) begin
					cmd.split_init = 1'b1;
					state_d        = S_SPLIT;
				end else begin
					cmd.emit = 1'b1;
					cmd.code = ST_NO_BLOCK;
					state_d  = S_IDLE;
				end
			end
			S_SPLIT: begin
				cmd.split_step = 1'b1;
				if (sts.split_end) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_F_RD: begin
				cmd.free_rd = 1'b1;
				state_d     = S_F_CHK;
			end
			S_F_CHK: begin
				if (!sts.head) begin
					cmd.emit = 1'b1;
					cmd.code = ST_BAD;
					state_d  = S_IDLE;
				end else if (sts.free) begin
					cmd.emit = 1'b1;
					cmd.code = ST_DUP_FREE;
					state_d  = S_IDLE;
				end else begin
					cmd.free_chk = 1'b1;
					state_d      = S_M_TEST;
				end
			end
			S_M_TEST: begin
				if (sts.at_top) begin
					state_d = S_F_FIN;
				end else begin
					cmd.buddy_rd = 1'b1;
					state_d      = S_M_CHK;
				end
			end
			S_M_CHK: begin
				if (sts.buddy_ok) begin
					cmd.merge = 1'b1;
					state_d   = S_M_TEST;
				end else begin
					state_d = S_F_FIN;
				end
			end
			S_F_FIN: begin
				cmd.free_fin = 1'b1;
				cmd.emit     = 1'b1;
				state_d      = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.emit;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	a_accept_disp: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == S_DISP))
		else $error("accepted transfer not dispatched");

	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> (busy && !done))
		else $error("activity during clearing pass");

endmodule

`default_nettype wire

// ===== sv/buddy_block_allocator.sv =====
`default_nettype none

// Binary buddy allocator over 32 top blocks of 128 KB, one 6-bit entry per
// 128-byte granule in a single-port RAM. After reset a clearing pass sets
// up the pool, with busy high. An allocate walks the block tiling from
// address zero, block by block, stopping at the first free block of the
// wanted order or at the pool end, then splits the smallest fitting free
// block found, one level at a time (up to ten levels). A free checks the
// block, then merges it with free buddies level by level. Each result shows
// for one cycle with done high; the receiver cannot stall, so it must take
// every transfer at that cycle. A new start may be given as soon as busy is low.
module buddy_block_allocator (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic                      operation,
	input  wire logic [bba_pkg::REQ_W-1:0] request_bytes,
	input  wire logic [bba_pkg::OFF_W-1:0] freed_offset,
	output logic                           done,
	output logic      [1:0]                status,
	output logic      [bba_pkg::OFF_W-1:0] payload_offset,
	output logic      [bba_pkg::ORD_W-1:0] granted_order
);

	import bba_pkg::*;

	cmd_t cmd;
	sts_t sts;

	bba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.sts    (sts),
		.cmd    (cmd)
	);

	bba_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.operation      (operation),
		.request_bytes  (request_bytes),
		.freed_offset   (freed_offset),
		.status         (status),
		.payload_offset (payload_offset),
		.granted_order  (granted_order)
	);

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import bba_pkg::*;

	localparam int RANDOM_ITEMS = 850;
	localparam int LIVE_CAP     = 24;
	localparam int BIG_REQUEST  = 131032;

	typedef struct {
		status_t          st;
		logic [OFF_W-1:0] off;
		logic [ORD_W-1:0] ord;
	} grant_t;

	typedef struct {
		logic             op;
		logic [REQ_W-1:0] req;
		logic [OFF_W-1:0] off;
		bit               typed;
		grant_t           want;
	} row_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic                operation;
	logic [REQ_W-1:0]    request_bytes;
	logic [OFF_W-1:0]    freed_offset;
	logic                done;
	logic [1:0]          status;
	logic [OFF_W-1:0]    payload_offset;
	logic [ORD_W-1:0]    granted_order;

	// Shadow of the granule table.
	bit       is_head [GRANULES];
	bit       is_free [GRANULES];
	bit [3:0] blk_ord [GRANULES];

	grant_t      grant_q[$];
	int unsigned live_q[$];
	int unsigned gone_q[$];
	bit          failed;
	bit          idle_on;

	buddy_block_allocator dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .request_bytes(request_bytes),
		.freed_offset(freed_offset), .done(done), .status(status),
		.payload_offset(payload_offset), .granted_order(granted_order)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(64'd200_000_000);
		$display("buddy_block_allocator regression: fail");
		$finish;
	end

	function automatic grant_t make_grant(status_t st, int unsigned g, int unsigned o);
		grant_t r;
		r.st = st;
		r.off = (st == ST_OK) ? OFF_W'(g * 128 + HEADER) : '0;
		r.ord = (st == ST_OK) ? ORD_W'(o) : '0;
		return r;
	endfunction

	task automatic pool_reset();
		for (int g = 0; g < GRANULES; g++) begin
			is_head[g] = (g % (1 << TOP_ORDER)) == 0;
			is_free[g] = is_head[g];
			blk_ord[g] = is_head[g] ? ORD_W'(TOP_ORDER) : '0;
		end
	endtask

	task automatic grant_block(input int unsigned sz, output grant_t r);
		int want;
		int best;
		int found_g;
		int g;
		int o;
		want = -1;
		best = TOP_ORDER + 1;
		found_g = -1;
		g = 0;
		if (sz == 0) begin
			r = make_grant(ST_BAD, 0, 0);
			return;
		end
		for (int k = 0; k <= TOP_ORDER; k++)
			if (want < 0 && sz + HEADER <= (128 << k))
				want = k;
		if (want < 0) begin
			r = make_grant(ST_BAD, 0, 0);
			return;
		end
		while (g < GRANULES) begin
			if (!is_head[g]) begin
				g++;
			end else begin
				o = (blk_ord[g] > TOP_ORDER) ? TOP_ORDER : blk_ord[g];
				if (is_free[g] && o >= want && o < best) begin
					best = o;
					found_g = g;
				end
				g += 1 << o;
			end
		end
		if (found_g < 0) begin
			r = make_grant(ST_NO_BLOCK, 0, 0);
			return;
		end
		o = best;
		while (o > want) begin
			o--;
			is_head[found_g + (1 << o)] = 1'b1;
			is_free[found_g + (1 << o)] = 1'b1;
			blk_ord[found_g + (1 << o)] = 4'(o);
		end
		blk_ord[found_g] = 4'(want);
		is_free[found_g] = 1'b0;
		r = make_grant(ST_OK, found_g, want);
	endtask

	task automatic release_block(input int unsigned off, output grant_t r);
		int unsigned g;
		int unsigned o;
		int unsigned bud;
		int unsigned lo;
		if (off < HEADER || (off - HEADER) % 128 != 0) begin
			r = make_grant(ST_BAD, 0, 0);
			return;
		end
		g = (off - HEADER) / 128;
		if (g >= GRANULES || !is_head[g]) begin
			r = make_grant(ST_BAD, 0, 0);
			return;
		end
		if (is_free[g]) begin
			r = make_grant(ST_DUP_FREE, 0, 0);
			return;
		end
		is_free[g] = 1'b1;
		o = (blk_ord[g] > TOP_ORDER) ? TOP_ORDER : blk_ord[g];
		while (o < TOP_ORDER) begin
			bud = g ^ (1 << o);
			if (bud >= GRANULES || !is_head[bud] || !is_free[bud] || blk_ord[bud] != o)
				break;
			lo = (bud < g) ? bud : g;
			is_head[lo ^ (1 << o)] = 1'b0;
			is_free[lo ^ (1 << o)] = 1'b0;
			blk_ord[lo ^ (1 << o)] = '0;
			o++;
			blk_ord[lo] = 4'(o);
			is_free[lo] = 1'b1;
			g = lo;
		end
		r = make_grant(ST_OK, g, o);
	endtask

	// Caller sits at a falling edge; returns at the falling edge after the transfer.
	task automatic send(input logic op, input int unsigned req, input int unsigned off,
			input bit typed, input grant_t typed_want);
		grant_t r;
		if (idle_on && $urandom_range(99) < 35) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		start <= 1'b1;
		operation <= op;
		request_bytes <= REQ_W'(req);
		freed_offset <= OFF_W'(off);
		while (busy)
			@(negedge clk);
		@(posedge clk);
		if (op)
			release_block(off, r);
		else
			grant_block(req, r);
		if (r.st == ST_OK && !op)
			live_q.push_back(r.off);
		if (op && r.st == ST_OK) begin
			gone_q.push_back(off);
			if (gone_q.size() > 16)
				void'(gone_q.pop_front());
		end
		grant_q.push_back(typed ? typed_want : r);
		@(negedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (grant_q.size() != 0)
			@(negedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (grant_q.size() == 0) begin
				$error("result with nothing expected: status %0d", status);
				failed = 1'b1;
			end else begin
				if (status !== grant_q[0].st) begin
					$error("status: expected %0d, actual %0d", grant_q[0].st, status);
					failed = 1'b1;
				end
				if (payload_offset !== grant_q[0].off) begin
					$error("payload_offset: expected %0d, actual %0d",
						grant_q[0].off, payload_offset);
					failed = 1'b1;
				end
				if (granted_order !== grant_q[0].ord) begin
					$error("granted_order: expected %0d, actual %0d",
						grant_q[0].ord, granted_order);
					failed = 1'b1;
				end
				void'(grant_q.pop_front());
			end
		end
	end

	initial begin
		row_t        rows[$];
		grant_t      none;
		int unsigned idx;
		int unsigned pick;
		int unsigned sz;
		int unsigned waited;

		failed = 1'b0;
		idle_on = 1'b1;
		none = make_grant(ST_BAD, 0, 0);
		arst_n = 1'b0;
		start = 1'b0;
		operation = 1'b0;
		request_bytes = '0;
		freed_offset = '0;
		pool_reset();

		rows = '{
			'{1'b0, 0,      0,       1, make_grant(ST_BAD, 0, 0)},
			'{1'b0, 131033, 0,       1, make_grant(ST_BAD, 0, 0)},
			'{1'b0, 131072, 0,       1, make_grant(ST_BAD, 0, 0)},
			'{1'b0, 1,      0,       1, make_grant(ST_OK, 0, 0)},
			'{1'b0, 88,     0,       0, none},
			'{1'b0, 89,     0,       0, none},
			'{1'b0, 131032, 0,       0, none},
			'{1'b1, 0,      0,       1, make_grant(ST_BAD, 0, 0)},
			'{1'b1, 0,      41,      1, make_grant(ST_BAD, 0, 0)},
			'{1'b1, 0,      4194303, 1, make_grant(ST_BAD, 0, 0)},
			'{1'b1, 0,      424,     1, make_grant(ST_BAD, 0, 0)},
			'{1'b1, 0,      168,     0, none},
			'{1'b1, 0,      168,     1, make_grant(ST_DUP_FREE, 0, 0)},
			'{1'b1, 0,      40,      0, none},
			'{1'b1, 0,      296,     0, none},
			'{1'b1, 0,      131112,  0, none},
			'{1'b0, 2000,   0,       0, none},
			'{1'b0, 262143, 0,       1, make_grant(ST_BAD, 0, 0)},
			'{1'b1, 0,      40,      0, none},
			'{1'b1, 0,      3145768, 0, none}
		};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (rows[i])
			send(rows[i].op, rows[i].req, rows[i].off, rows[i].typed, rows[i].want);
		live_q.delete();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			idle_on = !(n >= 300 && n < 450);
			if (n == 475) begin
				// Hold off until the pipeline is empty, then run the pool dry.
				drain();
				while (live_q.size() != 0)
					send(1'b1, 0, live_q.pop_front(), 0, none);
				for (int k = 0; k < TOP_BLOCKS + 1; k++)
					send(1'b0, BIG_REQUEST, 0, 0, none);
				while (live_q.size() != 0)
					send(1'b1, 0, live_q.pop_front(), 0, none);
			end
			pick = $urandom_range(99);
			if (live_q.size() >= LIVE_CAP)
				pick = 99;
			if (pick < 55) begin
				pick = $urandom_range(99);
				if (pick < 70)
					sz = $urandom_range(1, 600);
				else if (pick < 88)
					sz = $urandom_range(1, 16000);
				else if (pick < 95)
					sz = $urandom_range(1, 131072);
				else if (pick < 97)
					sz = 0;
				else
					sz = $urandom_range(131033, 262143);
				send(1'b0, sz, $urandom_range(4194303), 0, none);
			end else begin
				pick = $urandom_range(99);
				if (pick < 75 && live_q.size() != 0) begin
					idx = $urandom_range(live_q.size() - 1);
					sz = live_q[idx];
					live_q.delete(idx);
				end else if (pick < 88 && gone_q.size() != 0) begin
					sz = gone_q[$urandom_range(gone_q.size() - 1)];
				end else if (pick < 94) begin
					sz = HEADER + 128 * $urandom_range(GRANULES - 1);
				end else begin
					sz = $urandom_range(4194303);
				end
				send(1'b1, $urandom_range(262143), sz, 0, none);
			end
		end

		start <= 1'b0;
		waited = 0;
		while (grant_q.size() != 0 && waited < 2000000) begin
			@(negedge clk);
			waited++;
		end
		repeat (200) @(negedge clk);
		if (!failed && grant_q.size() == 0) begin
			$display("buddy_block_allocator regression: pass");
		end else begin
			$display("buddy_block_allocator regression: fail");
		end
		$finish;
	end

endmodule
